[src/hcmm_pkg.sv]
package hcmm_pkg;

  localparam int unsigned CART_BYTES = 32768;
  localparam int unsigned BOOT_BYTES = 256;
  localparam int unsigned WRAM_BYTES = 8192;
  localparam int unsigned HRAM_BYTES = 127;

  localparam int unsigned CART_AW = $clog2(CART_BYTES);
  localparam int unsigned BOOT_AW = $clog2(BOOT_BYTES);
  localparam int unsigned WRAM_AW = $clog2(WRAM_BYTES);
  localparam int unsigned HRAM_AW = $clog2(HRAM_BYTES + 1);

  localparam int unsigned CMD_Q_DEPTH = 2;
  localparam int unsigned CMD_Q_PW    = $clog2(CMD_Q_DEPTH);
  localparam int unsigned CMD_Q_CW    = $clog2(CMD_Q_DEPTH + 1);

  localparam logic [2:0] REQ_READ    = 3'd0;
  localparam logic [2:0] REQ_WRITE   = 3'd1;
  localparam logic [2:0] REQ_LD_CART = 3'd2;
  localparam logic [2:0] REQ_LD_BOOT = 3'd3;
  localparam logic [2:0] REQ_RESTART = 3'd4;

  localparam logic [15:0] ECHO_END  = 16'hFE00;
  localparam logic [15:0] HRAM_BASE = 16'hFF80;
  localparam logic [15:0] IE_ADDR   = 16'hFFFF;
  localparam logic [7:0]  IO_PAGE   = 8'hFF;

  localparam logic [7:0] IO_JOYP  = 8'h00;
  localparam logic [7:0] IO_SDATA = 8'h01;
  localparam logic [7:0] IO_SCTRL = 8'h02;
  localparam logic [7:0] IO_IFLAG = 8'h0F;
  localparam logic [7:0] IO_BOOT  = 8'h50;

  localparam logic [7:0] SERIAL_START = 8'h81;
  localparam logic [7:0] IFLAG_FORCE  = 8'hE0;
  localparam logic [7:0] IFLAG_RESET  = 8'hE1;
  localparam logic [7:0] BOOT_RELEASE = 8'h01;
  localparam logic [7:0] OPEN_BUS     = 8'hFF;

  typedef enum logic [3:0] {
    K_NONE,
    K_RD_ROM,
    K_RD_WRAM,
    K_RD_HRAM,
    K_RD_IE,
    K_RD_IO,
    K_WR_WRAM,
    K_WR_HRAM,
    K_WR_IE,
    K_WR_IO,
    K_SERIAL,
    K_LD_CART,
    K_LD_BOOT,
    K_RESTART
  } kind_e;

  typedef enum logic [2:0] {
    IO_SEL_JOYP,
    IO_SEL_SDATA,
    IO_SEL_SCTRL,
    IO_SEL_IFLAG,
    IO_SEL_BOOT
  } io_sel_e;

  typedef struct packed {
    kind_e               kind;
    io_sel_e             io;
    logic                low_page;
    logic [CART_AW-1:0]  idx;
    logic [7:0]          data;
  } cmd_t;

endpackage

[src/hcmm_if.sv]
interface hcmm_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [15:0] address;
  logic [7:0]  data;
  logic [7:0]  joypad_state;

  modport source (output valid, req_type, address, data, joypad_state, input ready);
  modport sink   (input valid, req_type, address, data, joypad_state, output ready);
endinterface

interface hcmm_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       serial_valid;
  logic [7:0] serial_byte;

  modport source (output valid, read_data, serial_valid, serial_byte, input ready);
  modport sink   (input valid, read_data, serial_valid, serial_byte, output ready);
endinterface

[src/hcmm_front.sv]
module hcmm_front (
  hcmm_req_if.sink        req_i,
  output logic            push_o,
  output hcmm_pkg::cmd_t  cmd_o,
  input  logic            full_i
);

  logic [15:0]      a;
  logic             is_rom, is_wram, is_io, is_hram, is_ie;
  logic             io_hit;
  hcmm_pkg::io_sel_e io_sel;

  assign a      = req_i.address;
  assign push_o = req_i.valid && !full_i;
  assign req_i.ready = !full_i;

  assign is_ie   = (a == hcmm_pkg::IE_ADDR);
  assign is_rom  = !a[15];
  assign is_wram = (a[15:14] == 2'b11) && (a < hcmm_pkg::ECHO_END);
  assign is_io   = (a[15:8] == hcmm_pkg::IO_PAGE) && !a[7];
  assign is_hram = (a >= hcmm_pkg::HRAM_BASE) && !is_ie;

  always_comb begin
    io_hit = 1'b1;
    io_sel = hcmm_pkg::IO_SEL_JOYP;
    unique case (a[7:0])
      hcmm_pkg::IO_JOYP:  io_sel = hcmm_pkg::IO_SEL_JOYP;
      hcmm_pkg::IO_SDATA: io_sel = hcmm_pkg::IO_SEL_SDATA;
      hcmm_pkg::IO_SCTRL: io_sel = hcmm_pkg::IO_SEL_SCTRL;
      hcmm_pkg::IO_IFLAG: io_sel = hcmm_pkg::IO_SEL_IFLAG;
      hcmm_pkg::IO_BOOT:  io_sel = hcmm_pkg::IO_SEL_BOOT;
      default:            io_hit = 1'b0;
    endcase
  end

  always_comb begin
    cmd_o.kind     = hcmm_pkg::K_NONE;
    cmd_o.io       = io_sel;
    cmd_o.low_page = (a[14:8] == 7'd0);
    cmd_o.idx      = a[hcmm_pkg::CART_AW-1:0];
    cmd_o.data     = req_i.data;
    unique case (req_i.req_type)
      hcmm_pkg::REQ_READ: begin
        if (is_ie)                  cmd_o.kind = hcmm_pkg::K_RD_IE;
        else if (is_rom)            cmd_o.kind = hcmm_pkg::K_RD_ROM;
        else if (is_wram)           cmd_o.kind = hcmm_pkg::K_RD_WRAM;
        else if (is_io && io_hit)   cmd_o.kind = hcmm_pkg::K_RD_IO;
        else if (is_hram)           cmd_o.kind = hcmm_pkg::K_RD_HRAM;
        if (io_sel == hcmm_pkg::IO_SEL_JOYP) cmd_o.data = req_i.joypad_state;
      end
      hcmm_pkg::REQ_WRITE: begin
        // joypad writes have no visible effect
        if (is_ie) cmd_o.kind = hcmm_pkg::K_WR_IE;
        else if (is_wram) cmd_o.kind = hcmm_pkg::K_WR_WRAM;
        else if (is_io && io_hit && io_sel != hcmm_pkg::IO_SEL_JOYP) begin
          if (io_sel == hcmm_pkg::IO_SEL_SCTRL && req_i.data == hcmm_pkg::SERIAL_START)
            cmd_o.kind = hcmm_pkg::K_SERIAL;
          else
            cmd_o.kind = hcmm_pkg::K_WR_IO;
        end else if (is_hram) cmd_o.kind = hcmm_pkg::K_WR_HRAM;
      end
      hcmm_pkg::REQ_LD_CART: begin
        if (!a[15]) cmd_o.kind = hcmm_pkg::K_LD_CART;
      end
      hcmm_pkg::REQ_LD_BOOT: begin
        if (a[15:8] == 8'd0) cmd_o.kind = hcmm_pkg::K_LD_BOOT;
      end
      hcmm_pkg::REQ_RESTART: cmd_o.kind = hcmm_pkg::K_RESTART;
      default: cmd_o.kind = hcmm_pkg::K_NONE;
    endcase
  end

endmodule

[src/hcmm_queue.sv]
module hcmm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  hcmm_pkg::cmd_t  push_cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output hcmm_pkg::cmd_t  pop_cmd_o
);

  hcmm_pkg::cmd_t                  slot_q [hcmm_pkg::CMD_Q_DEPTH];
  logic [hcmm_pkg::CMD_Q_PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [hcmm_pkg::CMD_Q_CW-1:0]   count_q, count_d;

  assign full_o    = (count_q == hcmm_pkg::CMD_Q_CW'(hcmm_pkg::CMD_Q_DEPTH));
  assign valid_o   = (count_q != '0);
  assign pop_cmd_o = slot_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !(pop_i && valid_o)) count_d = count_q + 1'b1;
    else if (!push_i && pop_i && valid_o) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i && valid_o) rd_ptr_q <= rd_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

[src/hcmm_back.sv]
module hcmm_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  input  logic            valid_i,
  input  hcmm_pkg::cmd_t  cmd_i,
  output logic            pop_o,
  hcmm_rsp_if.source      rsp_o
);

  typedef enum logic [2:0] {
    SRC_FF,
    SRC_CART,
    SRC_BOOT,
    SRC_WRAM,
    SRC_HRAM,
    SRC_REG
  } src_e;

  logic [7:0] cart_mem [hcmm_pkg::CART_BYTES];
  logic [7:0] boot_mem [hcmm_pkg::BOOT_BYTES];
  logic [7:0] wram_mem [hcmm_pkg::WRAM_BYTES];
  logic [7:0] hram_mem [hcmm_pkg::HRAM_BYTES];

  logic [7:0] cart_rd_q, boot_rd_q, wram_rd_q, hram_rd_q;

  logic       use_boot_q, overlay_q;
  logic [7:0] ie_q, sdata_q, sctrl_q, iflag_q, bootc_q;

  logic       out_valid_q;
  src_e       src_q, src_d;
  logic [7:0] reg_val_q, reg_val_d;
  logic       ser_valid_q;
  logic [7:0] ser_byte_q;

  logic [hcmm_pkg::CART_AW-1:0] cart_idx;
  logic [hcmm_pkg::BOOT_AW-1:0] boot_idx;
  logic [hcmm_pkg::WRAM_AW-1:0] wram_idx;
  logic [hcmm_pkg::HRAM_AW-1:0] hram_idx;
  logic                         use_boot_rd;

  assign cart_idx    = cmd_i.idx;
  assign boot_idx    = cmd_i.idx[hcmm_pkg::BOOT_AW-1:0];
  assign wram_idx    = cmd_i.idx[hcmm_pkg::WRAM_AW-1:0];
  assign hram_idx    = cmd_i.idx[hcmm_pkg::HRAM_AW-1:0];
  assign use_boot_rd = overlay_q && cmd_i.low_page;

  assign pop_o = valid_i && (!out_valid_q || rsp_o.ready);

  always_comb begin
    reg_val_d = hcmm_pkg::OPEN_BUS;
    unique case (cmd_i.io)
      hcmm_pkg::IO_SEL_JOYP:  reg_val_d = cmd_i.data;
      hcmm_pkg::IO_SEL_SDATA: reg_val_d = sdata_q;
      hcmm_pkg::IO_SEL_SCTRL: reg_val_d = sctrl_q;
      hcmm_pkg::IO_SEL_IFLAG: reg_val_d = iflag_q;
      hcmm_pkg::IO_SEL_BOOT:  reg_val_d = bootc_q;
      default:                reg_val_d = hcmm_pkg::OPEN_BUS;
    endcase
    if (cmd_i.kind == hcmm_pkg::K_RD_IE) reg_val_d = ie_q;
  end

  always_comb begin
    unique case (cmd_i.kind)
      hcmm_pkg::K_RD_ROM:  src_d = use_boot_rd ? SRC_BOOT : SRC_CART;
      hcmm_pkg::K_RD_WRAM: src_d = SRC_WRAM;
      hcmm_pkg::K_RD_HRAM: src_d = SRC_HRAM;
      hcmm_pkg::K_RD_IE,
      hcmm_pkg::K_RD_IO:   src_d = SRC_REG;
      default:             src_d = SRC_FF;
    endcase
  end

  // cartridge rom
  always_ff @(posedge clk_i) begin
    if (pop_o && cmd_i.kind == hcmm_pkg::K_LD_CART) cart_mem[cart_idx] <= cmd_i.data;
    if (pop_o && cmd_i.kind == hcmm_pkg::K_RD_ROM && !use_boot_rd)
      cart_rd_q <= cart_mem[cart_idx];
  end

  // boot rom
  always_ff @(posedge clk_i) begin
    if (pop_o && cmd_i.kind == hcmm_pkg::K_LD_BOOT) boot_mem[boot_idx] <= cmd_i.data;
    if (pop_o && cmd_i.kind == hcmm_pkg::K_RD_ROM && use_boot_rd)
      boot_rd_q <= boot_mem[boot_idx];
  end

  // work ram and echo
  always_ff @(posedge clk_i) begin
    if (pop_o && cmd_i.kind == hcmm_pkg::K_WR_WRAM) wram_mem[wram_idx] <= cmd_i.data;
    if (pop_o && cmd_i.kind == hcmm_pkg::K_RD_WRAM) wram_rd_q <= wram_mem[wram_idx];
  end

  // high ram
  always_ff @(posedge clk_i) begin
    if (pop_o && cmd_i.kind == hcmm_pkg::K_WR_HRAM) hram_mem[hram_idx] <= cmd_i.data;
    if (pop_o && cmd_i.kind == hcmm_pkg::K_RD_HRAM) hram_rd_q <= hram_mem[hram_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_boot_q  <= 1'b0;
      overlay_q   <= 1'b0;
      ie_q        <= '0;
      sdata_q     <= '0;
      sctrl_q     <= '0;
      iflag_q     <= '0;
      bootc_q     <= '0;
      out_valid_q <= 1'b0;
      src_q       <= SRC_FF;
      reg_val_q   <= '0;
      ser_valid_q <= 1'b0;
      ser_byte_q  <= '0;
    end else begin
      if (cfg_we_i) use_boot_q <= cfg_wdata_i;
      if (pop_o) out_valid_q <= 1'b1;
      else if (rsp_o.ready) out_valid_q <= 1'b0;
      if (pop_o) begin
        src_q       <= src_d;
        reg_val_q   <= reg_val_d;
        ser_valid_q <= (cmd_i.kind == hcmm_pkg::K_SERIAL);
        ser_byte_q  <= (cmd_i.kind == hcmm_pkg::K_SERIAL) ? sdata_q : 8'd0;
        case (cmd_i.kind)
          hcmm_pkg::K_WR_IE: ie_q <= cmd_i.data;
          hcmm_pkg::K_SERIAL: sdata_q <= '0;
          hcmm_pkg::K_WR_IO: begin
            case (cmd_i.io)
              hcmm_pkg::IO_SEL_SDATA: sdata_q <= cmd_i.data;
              hcmm_pkg::IO_SEL_SCTRL: sctrl_q <= cmd_i.data;
              hcmm_pkg::IO_SEL_IFLAG: iflag_q <= cmd_i.data | hcmm_pkg::IFLAG_FORCE;
              hcmm_pkg::IO_SEL_BOOT: begin
                if (cmd_i.data == hcmm_pkg::BOOT_RELEASE && overlay_q) overlay_q <= 1'b0;
                else bootc_q <= cmd_i.data;
              end
              default: ;
            endcase
          end
          hcmm_pkg::K_RESTART: begin
            overlay_q <= use_boot_q;
            if (!use_boot_q) begin
              iflag_q <= hcmm_pkg::IFLAG_RESET;
              bootc_q <= hcmm_pkg::BOOT_RELEASE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (src_q)
      SRC_CART: rsp_o.read_data = cart_rd_q;
      SRC_BOOT: rsp_o.read_data = boot_rd_q;
      SRC_WRAM: rsp_o.read_data = wram_rd_q;
      SRC_HRAM: rsp_o.read_data = hram_rd_q;
      SRC_REG:  rsp_o.read_data = reg_val_q;
      default:  rsp_o.read_data = hcmm_pkg::OPEN_BUS;
    endcase
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.serial_valid = ser_valid_q;
  assign rsp_o.serial_byte  = ser_byte_q;

endmodule

[src/handheld_console_memory_map.sv]
// an accepted word is written into the command queue, then registered in the output stage and offered from there
// throughput: one word per cycle while the response side is ready; each memory in the back end has a single port
// a two-word command queue lets the request and response sides stall independently
// reset clears the queue, output stage, i/o registers, overlay and config bit
// rom and ram contents are undefined until written; there is no clearing pass
module handheld_console_memory_map (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  hcmm_req_if.sink   req_i,
  hcmm_rsp_if.source rsp_o
);

  logic           push, full, pop, q_valid;
  hcmm_pkg::cmd_t push_cmd, pop_cmd;

  hcmm_front u_front (
    .req_i  (req_i),
    .push_o (push),
    .cmd_o  (push_cmd),
    .full_i (full)
  );

  hcmm_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_cmd_o  (pop_cmd)
  );

  hcmm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_i     (q_valid),
    .cmd_i       (pop_cmd),
    .pop_o       (pop),
    .rsp_o       (rsp_o)
  );

endmodule

[tb/hcmm_access_checker.sv]
module hcmm_access_checker
  import hcmm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  hcmm_req_if         req,
  hcmm_rsp_if         rsp,
  output int unsigned errors_o,
  output int unsigned backlog_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0] VRAM_BASE  = 16'h8000;
  localparam logic [15:0] WRAM_BASE  = 16'hC000;
  localparam logic [7:0]  JOYP_RESET = 8'hCF;

  typedef struct packed {
    logic [7:0] read_data;
    logic       serial_valid;
    logic [7:0] serial_byte;
  } bus_reply_t;

  logic [7:0] cart_rom [CART_BYTES];
  logic [7:0] boot_img [BOOT_BYTES];
  logic [7:0] wram [WRAM_BYTES];
  logic [7:0] hram [HRAM_BYTES];
  logic [7:0] ie_reg, joyp_reg, sdata_reg, sctrl_reg, iflag_reg, bootctl_reg;
  logic       overlay, boot_cfg;

  bus_reply_t  replies_due [$];
  int unsigned words_seen;

  function automatic void flag_fault(string what);
    if (errors_o < 10) $display("%t checker: %s", $time, what);
    errors_o++;
  endfunction

  function automatic logic [7:0] io_byte(logic [7:0] sel, logic [7:0] pad);
    case (sel)
      IO_JOYP:  return pad;
      IO_SDATA: return sdata_reg;
      IO_SCTRL: return sctrl_reg;
      IO_IFLAG: return iflag_reg;
      IO_BOOT:  return bootctl_reg;
      default:  return OPEN_BUS;
    endcase
  endfunction

  function automatic void io_store(logic [7:0] sel, logic [7:0] v);
    case (sel)
      IO_JOYP:  joyp_reg = v;
      IO_SDATA: sdata_reg = v;
      IO_SCTRL: sctrl_reg = v;
      IO_IFLAG: iflag_reg = v | IFLAG_FORCE;
      IO_BOOT: begin
        if (v == BOOT_RELEASE && overlay) overlay = 1'b0;
        else bootctl_reg = v;
      end
      default: ;
    endcase
  endfunction

  // work ram and its echo both start on 8 KiB boundaries, high ram on a 128 byte one
  function automatic logic [7:0] bus_byte(logic [15:0] a, logic [7:0] pad);
    if (a == IE_ADDR) return ie_reg;
    if (a < VRAM_BASE) begin
      if (overlay && a < BOOT_BYTES) return boot_img[a[BOOT_AW-1:0]];
      return cart_rom[a[CART_AW-1:0]];
    end
    if (a >= WRAM_BASE && a < ECHO_END) return wram[a[WRAM_AW-1:0]];
    if (a[15:8] == IO_PAGE && a < HRAM_BASE) return io_byte(a[7:0], pad);
    if (a >= HRAM_BASE) return hram[a[HRAM_AW-1:0]];
    return OPEN_BUS;
  endfunction

  function automatic void bus_store(logic [15:0] a, logic [7:0] v);
    if (a == IE_ADDR) ie_reg = v;
    else if (a >= WRAM_BASE && a < ECHO_END) wram[a[WRAM_AW-1:0]] = v;
    else if (a[15:8] == IO_PAGE && a < HRAM_BASE) io_store(a[7:0], v);
    else if (a >= HRAM_BASE) hram[a[HRAM_AW-1:0]] = v;
  endfunction

  function automatic bus_reply_t apply_word(logic [2:0] kind, logic [15:0] a,
                                            logic [7:0] d, logic [7:0] pad);
    bus_reply_t r;
    r.read_data    = OPEN_BUS;
    r.serial_valid = 1'b0;
    r.serial_byte  = 8'h00;
    case (kind)
      REQ_READ: r.read_data = bus_byte(a, pad);
      REQ_WRITE: begin
        if (a == {IO_PAGE, IO_SCTRL} && d == SERIAL_START) begin
          r.serial_valid = 1'b1;
          r.serial_byte  = sdata_reg;
          sdata_reg      = 8'h00;
        end else begin
          bus_store(a, d);
        end
      end
      REQ_LD_CART: if (a < CART_BYTES) cart_rom[a[CART_AW-1:0]] = d;
      REQ_LD_BOOT: if (a < BOOT_BYTES) boot_img[a[BOOT_AW-1:0]] = d;
      REQ_RESTART: begin
        overlay = boot_cfg;
        if (!boot_cfg) begin
          joyp_reg    = JOYP_RESET;
          iflag_reg   = IFLAG_RESET;
          bootctl_reg = BOOT_RELEASE;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bus_reply_t want, got;
    if (!rst_ni) begin
      ie_reg      = 8'h00;
      joyp_reg    = 8'h00;
      sdata_reg   = 8'h00;
      sctrl_reg   = 8'h00;
      iflag_reg   = 8'h00;
      bootctl_reg = 8'h00;
      overlay     = 1'b0;
      boot_cfg    = 1'b0;
      replies_due.delete();
      words_seen  = 0;
      errors_o    = 0;
      backlog_o   = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.read_data    = rsp.read_data;
        got.serial_valid = rsp.serial_valid;
        got.serial_byte  = rsp.serial_byte;
        if (replies_due.size() == 0) begin
          flag_fault($sformatf("unexpected word rd=%h sv=%b sb=%h",
                               got.read_data, got.serial_valid, got.serial_byte));
        end else begin
          want = replies_due.pop_front();
          if (got.read_data !== want.read_data || got.serial_valid !== want.serial_valid ||
              got.serial_byte !== want.serial_byte) begin
            flag_fault($sformatf("word %0d: expected rd=%h sv=%b sb=%h, got rd=%h sv=%b sb=%h",
                                 words_seen, want.read_data, want.serial_valid,
                                 want.serial_byte, got.read_data, got.serial_valid,
                                 got.serial_byte));
          end
        end
        words_seen++;
      end
      if (cfg_we_i) boot_cfg = cfg_wdata_i;
      if (req.valid && req.ready) begin
        replies_due.push_back(apply_word(req.req_type, req.address, req.data,
                                         req.joypad_state));
      end
      backlog_o = replies_due.size();
    end
  end

endmodule

[tb/handheld_console_memory_map_test.sv]
module handheld_console_memory_map_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hcmm_pkg::*;

  localparam int unsigned PHASE_WORDS = 356;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned HOLD_CYCLES = 64;

  localparam logic [2:0]  REQ_SPARE_LO = 3'd5;
  localparam logic [2:0]  REQ_SPARE_HI = 3'd7;
  localparam logic [15:0] VRAM_BASE    = 16'h8000;
  localparam logic [15:0] XRAM_END     = 16'hBFFF;
  localparam logic [15:0] WRAM_BASE    = 16'hC000;
  localparam logic [15:0] ECHO_BASE    = 16'hE000;
  localparam logic [15:0] OAM_BASE     = 16'hFE00;
  localparam logic [15:0] OAM_END      = 16'hFEFF;
  localparam logic [7:0]  IO_DMA       = 8'h46;
  localparam logic [5:0][7:0] IO_KNOWN = {IO_JOYP, IO_SDATA, IO_SCTRL, IO_IFLAG, IO_DMA, IO_BOOT};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we, cfg_wdata;
  int unsigned mismatch_cnt, backlog;

  hcmm_req_if req_bus ();
  hcmm_rsp_if rsp_bus ();

  bit cart_seen [CART_BYTES];
  bit boot_seen [BOOT_BYTES];
  bit wram_seen [WRAM_BYTES];
  bit hram_seen [HRAM_BYTES];
  int unsigned cart_list [$];
  int unsigned wram_list [$];
  int unsigned hram_list [$];

  int unsigned burst_left;
  bit          hold_off_req;

  handheld_console_memory_map i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req_bus),
    .rsp_o      (rsp_bus)
  );

  hcmm_access_checker i_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .req        (req_bus),
    .rsp        (rsp_bus),
    .errors_o   (mismatch_cnt),
    .backlog_o  (backlog)
  );

  always #1 clk_i = ~clk_i;

  // remember which store entries hold a byte so reads never hit an unwritten one
  function automatic void note_store(logic [2:0] kind, logic [15:0] a);
    int unsigned i;
    case (kind)
      REQ_LD_CART: begin
        if (a < CART_BYTES && !cart_seen[a]) begin
          cart_seen[a] = 1'b1;
          cart_list.push_back(a);
        end
      end
      REQ_LD_BOOT: if (a < BOOT_BYTES) boot_seen[a] = 1'b1;
      REQ_WRITE: begin
        if (a >= WRAM_BASE && a < ECHO_END) begin
          i = a[WRAM_AW-1:0];
          if (!wram_seen[i]) begin
            wram_seen[i] = 1'b1;
            wram_list.push_back(i);
          end
        end else if (a >= HRAM_BASE && a < IE_ADDR) begin
          i = a - HRAM_BASE;
          if (!hram_seen[i]) begin
            hram_seen[i] = 1'b1;
            hram_list.push_back(i);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r == 0) burst_left = $urandom_range(20, 80);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_word(logic [2:0] kind, logic [15:0] a, logic [7:0] d, logic [7:0] pad);
    int unsigned gap;
    note_store(kind, a);
    req_bus.valid        <= 1'b1;
    req_bus.req_type     <= kind;
    req_bus.address      <= a;
    req_bus.data         <= d;
    req_bus.joypad_state <= pad;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    gap = gap_len();
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic set_boot_cfg(logic v);
    req_bus.valid <= 1'b0;
    do @(negedge clk_i); while (backlog != 0);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [15:0] io_addr();
    if ($urandom_range(0, 9) < 6) return {IO_PAGE, IO_KNOWN[$urandom_range(0, 5)]};
    return {IO_PAGE, 1'b0, 7'($urandom)};
  endfunction

  function automatic logic [15:0] pick_read_addr();
    int unsigned r, i;
    r = $urandom_range(0, 99);
    if (r < 22 && cart_list.size() != 0) begin
      i = cart_list[$urandom_range(0, cart_list.size() - 1)];
      if (i >= BOOT_BYTES || boot_seen[i]) return 16'(i);
    end else if (r < 40 && wram_list.size() != 0) begin
      i = wram_list[$urandom_range(0, wram_list.size() - 1)];
      if (i < ECHO_END - ECHO_BASE && $urandom_range(0, 1) == 1) return 16'(ECHO_BASE + i);
      return 16'(WRAM_BASE + i);
    end else if (r < 52 && hram_list.size() != 0) begin
      return 16'(HRAM_BASE + hram_list[$urandom_range(0, hram_list.size() - 1)]);
    end else if (r < 56) begin
      return IE_ADDR;
    end else if (r < 82) begin
      return io_addr();
    end
    if ($urandom_range(0, 2) != 0) return 16'($urandom_range(VRAM_BASE, XRAM_END));
    return 16'($urandom_range(OAM_BASE, OAM_END));
  endfunction

  function automatic logic [15:0] pick_write_addr();
    int unsigned r, i;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      i = $urandom_range(0, WRAM_BYTES - 1);
      if (i < ECHO_END - ECHO_BASE && $urandom_range(0, 1) == 1) return 16'(ECHO_BASE + i);
      return 16'(WRAM_BASE + i);
    end
    if (r < 46) return 16'(HRAM_BASE + $urandom_range(0, HRAM_BYTES - 1));
    if (r < 74) return io_addr();
    if (r < 79) return IE_ADDR;
    return 16'($urandom);
  endfunction

  task automatic random_word();
    int unsigned r;
    logic [15:0] a;
    logic [7:0]  d;
    r = $urandom_range(0, 99);
    d = 8'($urandom);
    if (r < 38 || r >= 93) begin
      send_word(REQ_READ, pick_read_addr(), d, 8'($urandom));
    end else if (r < 66) begin
      a = pick_write_addr();
      if (a == {IO_PAGE, IO_SCTRL} && $urandom_range(0, 1) == 1) d = SERIAL_START;
      if (a == {IO_PAGE, IO_BOOT} && $urandom_range(0, 1) == 1) d = BOOT_RELEASE;
      send_word(REQ_WRITE, a, d, 8'($urandom));
    end else if (r < 76) begin
      case ($urandom_range(0, 9))
        0:       a = 16'($urandom_range(CART_BYTES, 16'hFFFF));
        1, 2, 3: a = 16'($urandom_range(0, BOOT_BYTES - 1));
        default: a = 16'($urandom_range(0, CART_BYTES - 1));
      endcase
      send_word(REQ_LD_CART, a, d, 8'($urandom));
    end else if (r < 86) begin
      if ($urandom_range(0, 7) == 0) a = 16'($urandom_range(BOOT_BYTES, 16'hFFFF));
      else a = 16'($urandom_range(0, BOOT_BYTES - 1));
      send_word(REQ_LD_BOOT, a, d, 8'($urandom));
    end else if (r < 90) begin
      send_word(REQ_RESTART, 16'($urandom), d, 8'($urandom));
    end else begin
      send_word(3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI)), 16'($urandom), d,
                8'($urandom));
    end
  endtask

  initial begin
    req_bus.valid        = 1'b0;
    req_bus.req_type     = REQ_READ;
    req_bus.address      = 16'h0000;
    req_bus.data         = 8'h00;
    req_bus.joypad_state = 8'h00;
    cfg_we               = 1'b0;
    cfg_wdata            = 1'b0;
    burst_left           = 0;
    hold_off_req         = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_boot_cfg(1'b1);
    send_word(REQ_LD_CART, 16'h0000, 8'hA5, 8'h00);
    send_word(REQ_LD_CART, 16'h00FF, 8'h96, 8'h00);
    send_word(REQ_LD_CART, 16'h7FFF, 8'h3C, 8'h00);
    send_word(REQ_LD_BOOT, 16'h0000, 8'h5A, 8'h00);
    send_word(REQ_LD_BOOT, 16'h00FF, 8'hC3, 8'h00);
    send_word(REQ_LD_CART, 16'h8000, 8'h11, 8'h00);
    send_word(REQ_LD_BOOT, 16'h0100, 8'h22, 8'h00);
    send_word(REQ_READ, 16'h0000, 8'h00, 8'h00);
    send_word(REQ_RESTART, 16'h0000, 8'h00, 8'h00);
    send_word(REQ_READ, 16'h00FF, 8'h00, 8'h00);
    send_word(REQ_WRITE, {IO_PAGE, IO_BOOT}, BOOT_RELEASE, 8'h00);
    send_word(REQ_READ, 16'h00FF, 8'h00, 8'h00);
    send_word(REQ_WRITE, 16'hFDFF, 8'h00, 8'h00);
    send_word(REQ_READ, 16'hDDFF, 8'hFF, 8'h00);
    send_word(REQ_WRITE, 16'hFFFE, 8'hFF, 8'h00);
    send_word(REQ_READ, 16'hFFFE, 8'h00, 8'h00);
    send_word(REQ_WRITE, {IO_PAGE, IO_SDATA}, 8'hAB, 8'h00);
    send_word(REQ_WRITE, {IO_PAGE, IO_SCTRL}, SERIAL_START, 8'h00);
    send_word(REQ_READ, {IO_PAGE, IO_SDATA}, 8'h00, 8'h00);
    send_word(REQ_WRITE, {IO_PAGE, IO_IFLAG}, 8'h00, 8'h00);
    send_word(REQ_READ, {IO_PAGE, IO_IFLAG}, 8'h00, 8'h00);
    send_word(REQ_READ, {IO_PAGE, IO_JOYP}, 8'h00, 8'hFF);
    send_word(REQ_READ, 16'h7FFF, 8'h00, 8'h00);
    send_word(REQ_WRITE, IE_ADDR, 8'h5A, 8'h00);
    send_word(REQ_READ, IE_ADDR, 8'h00, 8'h00);
    send_word(REQ_SPARE_HI, 16'hFFFF, 8'hFF, 8'hFF);

    for (int p = 0; p < 4; p++) begin
      set_boot_cfg(p[0]);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n == PHASE_WORDS / 2) begin
          hold_off_req = 1'b1;
          burst_left   = 40;
        end
        random_word();
      end
    end

    req_bus.valid <= 1'b0;
    do @(negedge clk_i); while (backlog != 0);
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // response side: random stalls, stretches of full rate, and a long hold-off on request
  initial begin
    int unsigned stall_left, free_left, r;
    stall_left    = 0;
    free_left     = 0;
    rsp_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left   = HOLD_CYCLES;
        free_left    = 0;
      end
      if (stall_left != 0) begin
        stall_left--;
        rsp_bus.ready <= 1'b0;
      end else if (free_left != 0) begin
        free_left--;
        rsp_bus.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2) begin
          free_left = $urandom_range(30, 120);
          rsp_bus.ready <= 1'b1;
        end else if (r < 76) begin
          rsp_bus.ready <= 1'b1;
        end else if (r < 97) begin
          stall_left = $urandom_range(0, 2);
          rsp_bus.ready <= 1'b0;
        end else begin
          stall_left = $urandom_range(7, 29);
          rsp_bus.ready <= 1'b0;
        end
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

endmodule
